### rtl/lcdt_pkg.sv
// package: item types, op codes and constants for the loop current dac transfer
`timescale 1ns / 1ps
package lcdt_pkg;

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned CUR_W   = 24;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned DELTA_W = CODE_W + 1;

  localparam logic [CNT_W-1:0] DAC_MAX = 16'd4095;
  localparam logic [15:0]      LAST_CODE_RESET = 16'hFFFF;

  localparam logic [CODE_W-1:0] CODE_AT_4MA_RESET  = 12'd89;
  localparam logic [CODE_W-1:0] CODE_AT_20MA_RESET = 12'd3650;

  localparam logic REG_CODE_AT_4MA  = 1'b0;
  localparam logic REG_CODE_AT_20MA = 1'b1;

  // 2^24 / (delta * 16) == 2^20 / delta
  localparam int unsigned QUOT_W    = 21;
  localparam int unsigned DIV_STEPS = QUOT_W;
  localparam int unsigned DIVCNT_W  = $clog2(DIV_STEPS + 1);
  localparam logic [QUOT_W-1:0] DIV_DIVIDEND = 21'h100000;

  localparam int unsigned MUL_A_W = QUOT_W + 1;
  localparam int unsigned MUL_B_W = 18;

  typedef enum logic [1:0] {
    OP_CUR_TO_DAC = 2'd0,
    OP_DAC_TO_CUR = 2'd1,
    OP_RAW_WRITE  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [CUR_W-1:0] req_current;
    logic [CNT_W-1:0]        code_in;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]       code_out;
    logic                    dac_write;
    logic signed [RES_W-1:0] current_result;
  } out_item_t;

endpackage

### rtl/loop_current_dac_transfer.sv
// top level: two-point 4-20 ma calibration, sequencer around a divider and a shared mac
//
//  channel  | signals                             | direction
//  ---------+-------------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_data_i   | input
//  out      | out_valid_o, out_ready_i, out_data_o| output
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i     | input
//
// op 0 steps through prep, mul and done; op 2 and op 3 go from prep to done; op 1
// waits in div on the one-bit-per-cycle divider that forms the inverse slope (skipped
// when the calibration codes are equal), then mulstart, mul and done; one item at a time.
// reset clears the sequencer and output valid, loads the calibration resets and
// marks the last code as never written. a result held in the output register
// does not block acceptance; the next item waits at its last step until the
// output register is free.
`timescale 1ns / 1ps
module loop_current_dac_transfer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lcdt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lcdt_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lcdt_pkg::CODE_W-1:0]   cfg_data_i
);
  import lcdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MULSTART,
    S_MUL,
    S_DONE
  } state_e;

  state_e    state_q;
  in_item_t  in_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic [CODE_W-1:0] c4_q, c20_q;
  logic [15:0]       last_code_q;
  logic signed [MUL_A_W-1:0] inv_q;

  logic signed [DELTA_W-1:0] delta;
  logic [15:0]               slope_sh;
  logic signed [RES_W-1:0]   intercept;
  logic signed [16:0]        neg_int;
  logic [CODE_W-1:0]         delta_abs;
  logic [CODE_W-1:0]         counts_clamped;
  logic signed [15:0]        d_hi;
  logic [CODE_W-1:0]         code_op0;
  logic                      out_free;
  logic                      in_acc;

  logic                      div_start, div_done;
  logic [QUOT_W-1:0]         quot;
  logic                      mac_en;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [RES_W-1:0]   mac_add, mac_res;

  assign delta     = $signed({1'b0, c20_q}) - $signed({1'b0, c4_q});
  assign slope_sh  = {delta[CODE_W-1:0], 4'b0000};
  assign intercept = $signed({4'b0000, c4_q, 16'h0000})
                   - $signed({{5{delta[DELTA_W-1]}}, delta, 14'h0000});
  assign neg_int   = 17'sd0 - $signed({intercept[RES_W-1], intercept[RES_W-1:16]});
  assign delta_abs = delta[DELTA_W-1] ? CODE_W'(-delta) : delta[CODE_W-1:0];

  assign counts_clamped = (in_q.code_in > DAC_MAX) ? DAC_MAX[CODE_W-1:0]
                                                    : in_q.code_in[CODE_W-1:0];

  assign d_hi = mac_res[RES_W-1:16];
  always_comb begin
    if (d_hi[15]) begin
      code_op0 = '0;
    end else if (d_hi[14:0] > DAC_MAX[14:0]) begin
      code_op0 = DAC_MAX[CODE_W-1:0];
    end else begin
      code_op0 = d_hi[CODE_W-1:0];
    end
  end

  always_comb begin
    if (in_q.op == OP_DAC_TO_CUR) begin
      mac_a   = inv_q;
      mac_b   = $signed({6'b000000, counts_clamped})
              + $signed({neg_int[16], neg_int});
      mac_add = '0;
    end else begin
      mac_a   = $signed({6'b000000, slope_sh});
      mac_b   = $signed({{2{in_q.req_current[CUR_W-1]}}, in_q.req_current[CUR_W-1:8]});
      mac_add = intercept;
    end
  end

  always_comb begin
    out_d = '0;
    unique case (in_q.op)
      OP_CUR_TO_DAC: begin
        out_d.code_out  = code_op0;
        out_d.dac_write = 1'b1;
      end
      OP_DAC_TO_CUR: begin
        out_d.code_out       = counts_clamped;
        out_d.current_result = mac_res;
      end
      OP_RAW_WRITE: begin
        out_d.code_out  = counts_clamped;
        out_d.dac_write = ({4'h0, counts_clamped} != last_code_q);
      end
      default: out_d = '0;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign div_start  = (state_q == S_PREP) && (in_q.op == OP_DAC_TO_CUR) && (delta != '0);
  assign mac_en     = ((state_q == S_PREP) && (in_q.op == OP_CUR_TO_DAC))
                   || (state_q == S_MULSTART);

  lcdt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (delta_abs),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  lcdt_mac u_mac (
    .clk_i    (clk_i),
    .en_i     (mac_en),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .addend_i (mac_add),
    .res_o    (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      c4_q        <= CODE_AT_4MA_RESET;
      c20_q       <= CODE_AT_20MA_RESET;
      last_code_q <= LAST_CODE_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CODE_AT_4MA) begin
          c4_q <= cfg_data_i;
        end else begin
          c20_q <= cfg_data_i;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          priority if (in_q.op == OP_CUR_TO_DAC) begin
            state_q <= S_MUL;
          end else if (in_q.op == OP_DAC_TO_CUR) begin
            state_q <= (delta != '0) ? S_DIV : S_MULSTART;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_MULSTART;
          end
        end
        S_MULSTART: state_q <= S_MUL;
        S_MUL:      state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            if (out_d.dac_write) begin
              last_code_q <= {4'h0, out_d.code_out};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (state_q == S_PREP) begin
      inv_q <= '0;
    end else if (div_done) begin
      inv_q <= delta[DELTA_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_PREP && !in_ready_o)
    else $error("accepted transaction did not enter preparation");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished transaction not loaded into output register");

  a_last_code_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_code_q) |-> $past(state_q == S_DONE) && out_valid_q && out_q.dac_write)
    else $error("last code changed without a dac write");

endmodule

### rtl/lcdt_div.sv
// iterative restoring divider for the inverse slope, one quotient bit per cycle
`timescale 1ns / 1ps
module lcdt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lcdt_pkg::CODE_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [lcdt_pkg::QUOT_W-1:0]  quot_o
);
  import lcdt_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic [CODE_W-1:0]   div_q, div_d;
  logic [CODE_W-1:0]   rem_q, rem_d;
  logic [QUOT_W-1:0]   q_q, q_d;

  logic [CODE_W:0] rem_sh;
  logic [CODE_W:0] rem_sub;
  logic            fits;

  assign rem_sh  = {rem_q, q_q[QUOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign fits    = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIVCNT_W'(DIV_STEPS);
      div_d  = divisor_i;
      rem_d  = '0;
      q_d    = DIV_DIVIDEND;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[CODE_W-1:0] : rem_sh[CODE_W-1:0];
      q_d   = {q_q[QUOT_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIVCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

### rtl/lcdt_mac.sv
// shared signed multiply-add with registered result
`timescale 1ns / 1ps
module lcdt_mac (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [lcdt_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [lcdt_pkg::MUL_B_W-1:0] b_i,
  input  logic signed [lcdt_pkg::RES_W-1:0]   addend_i,
  output logic signed [lcdt_pkg::RES_W-1:0]   res_o
);
  import lcdt_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [RES_W-1:0]           res_q, res_d;

  assign prod  = a_i * b_i;
  assign res_d = $signed(prod[RES_W-1:0]) + addend_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
